### design/segment_polygon_intersection_defines.svh
// ----------------------------------------------------------------------------
// Segment polygon intersection assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POLYGON_INTERSECTION_DEFINES_SVH
`define SEGMENT_POLYGON_INTERSECTION_DEFINES_SVH

// same-cycle implication
`define SPI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/segpoly_pkg.sv
// ----------------------------------------------------------------------------
// Segment polygon intersection package
// Shared constants, queue status type and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package segpoly_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int CW_LIMIT        = 30;
   localparam int MAX_VERTICES    = 256;
   localparam int EDGE_CNT_W      = 9;
   localparam logic [EDGE_CNT_W-1:0] EDGE_CNT_MAX = '1;
   localparam int HIT_IDX_W       = 8;
   localparam logic [HIT_IDX_W-1:0] HIT_IDX_MAX = '1;
   localparam int QUEUE_DEPTH     = 4;
   localparam int RSP_DATA_W      = 16;

   typedef struct packed {
      logic full;
      logic empty;
   } segpoly_qstat_type;

   function automatic int cw_eff(input int cw);
      return (cw > CW_LIMIT) ? CW_LIMIT : cw;
   endfunction

endpackage

### design/segment_polygon_intersection.sv
// ----------------------------------------------------------------------------
// Segment polygon intersection
// Test a query segment against every edge of a streamed polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry one polygon vertex each plus the query segment; req_tlast
//   marks the final vertex. Each vertex after the first closes an edge, and the
//   final vertex also closes the wrap-around edge to the first vertex.
//   One response is produced per polygon, on its final vertex, and none for
//   other vertices.
//   Throughput: one vertex per cycle while the queue is not full; both edges a
//   vertex can close are tested side by side in two lanes of six multipliers each.
//   Path: the final vertex passes through the queue, then the difference,
//   product, cross-product and compare stages, then the response register;
//   it waits behind queued entries and while a response waits for rsp_tready.
//   Stall: while a response waits for rsp_tready the edge pipeline holds; the
//   four-entry queue keeps taking requests until it is full.
//   Reset: clears vertex tracking, queue, pipeline and accumulated hit state;
//   the next vertex starts a new polygon.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_polygon_intersection #(
   parameter int COORD_WIDTH = segpoly_pkg::COORD_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y, vertex_x, vertex_y
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // intersects, hit_edge[7:0], count_overflow
   output logic [segpoly_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int EW = 10 * segpoly_pkg::cw_eff(COORD_WIDTH) + 2;

   segpoly_pkg::segpoly_qstat_type qstat;
   logic          push, pop;
   logic [EW-1:0] push_data, pop_data;

   segpoly_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .qstat_i     (qstat),
      .push_o      (push),
      .push_data_o (push_data)
   );

   segpoly_queue #(
      .WIDTH (EW),
      .DEPTH (segpoly_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .pop_i       (pop),
      .pop_data_o  (pop_data),
      .stat_o      (qstat)
   );

   segpoly_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data_i (pop_data),
      .qstat_i    (qstat),
      .pop_o      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### design/segpoly_queue.sv
// ----------------------------------------------------------------------------
// Segment polygon request queue
// Small register FIFO between the classifying front and the edge-test back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_polygon_intersection_defines.svh"

module segpoly_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = segpoly_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_i,
   input  logic [WIDTH-1:0]              push_data_i,
   input  logic                          pop_i,
   output logic [WIDTH-1:0]              pop_data_o,
   output segpoly_pkg::segpoly_qstat_type stat_o
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   assign pop_data_o   = mem_ff[rd_ptr_ff];
   assign stat_o.full  = (cnt_ff == (AW+1)'(DEPTH));
   assign stat_o.empty = (cnt_ff == '0);

   `SPI_ASSERT_NXT(a_q_fill, push_i && !pop_i, cnt_ff == $past(cnt_ff) + 1'b1, "count missed a push")
   `SPI_ASSERT_NXT(a_q_drain, pop_i && !push_i, cnt_ff == $past(cnt_ff) - 1'b1, "count missed a pop")
   `SPI_ASSERT_IMP(a_q_under, pop_i, !stat_o.empty, "pop from empty queue")
   `SPI_ASSERT_IMP(a_q_over, push_i, !stat_o.full, "push into full queue")

endmodule

### design/segpoly_front.sv
// ----------------------------------------------------------------------------
// Segment polygon front end
// Accept vertex requests, track first and previous vertex, build edge pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segpoly_front #(
   parameter int COORD_WIDTH = segpoly_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                            req_tlast,
   input  segpoly_pkg::segpoly_qstat_type  qstat_i,
   output logic                            push_o,
   output logic [10*segpoly_pkg::cw_eff(COORD_WIDTH)+1:0] push_data_o
);

   localparam int CW = segpoly_pkg::cw_eff(COORD_WIDTH);

   typedef struct packed {
      logic signed [CW-1:0] sx0;
      logic signed [CW-1:0] sy0;
      logic signed [CW-1:0] sx1;
      logic signed [CW-1:0] sy1;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] fx;
      logic signed [CW-1:0] fy;
      logic                 a_valid;
      logic                 last;
   } segpoly_entry_type;

   logic                 accept;
   logic signed [CW-1:0] vx, vy;
   logic                 have_ff, have_in;
   logic signed [CW-1:0] first_x_ff, first_y_ff, first_x_in, first_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_y_ff;
   segpoly_entry_type    entry;

   assign req_tready = !qstat_i.full;
   assign accept     = req_tvalid && req_tready;
   assign vx         = req_tdata[4*COORD_WIDTH +: CW];
   assign vy         = req_tdata[5*COORD_WIDTH +: CW];

   always_comb begin
      have_in    = have_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      if (accept) begin
         if (!have_ff) begin
            first_x_in = vx;
            first_y_in = vy;
         end
         have_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      if (accept) begin
         prev_x_ff <= vx;
         prev_y_ff <= vy;
      end
   end

   always_comb begin
      entry.sx0     = req_tdata[0*COORD_WIDTH +: CW];
      entry.sy0     = req_tdata[1*COORD_WIDTH +: CW];
      entry.sx1     = req_tdata[2*COORD_WIDTH +: CW];
      entry.sy1     = req_tdata[3*COORD_WIDTH +: CW];
      entry.px      = prev_x_ff;
      entry.py      = prev_y_ff;
      entry.vx      = vx;
      entry.vy      = vy;
      entry.fx      = first_x_in;
      entry.fy      = first_y_in;
      entry.a_valid = have_ff;
      entry.last    = req_tlast;
   end

   assign push_o      = accept;
   assign push_data_o = entry;

endmodule

### design/segpoly_back.sv
// ----------------------------------------------------------------------------
// Segment polygon back end
// Two-lane cross-product edge test pipeline, hit accumulation, response reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segpoly_back #(
   parameter int COORD_WIDTH = segpoly_pkg::COORD_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [10*segpoly_pkg::cw_eff(COORD_WIDTH)+1:0]  pop_data_i,
   input  segpoly_pkg::segpoly_qstat_type                  qstat_i,
   output logic                                            pop_o,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [segpoly_pkg::RSP_DATA_W-1:0]              rsp_tdata
);

   localparam int CW = segpoly_pkg::cw_eff(COORD_WIDTH);
   localparam int D  = CW + 1;
   localparam int P  = 2 * D;
   localparam int S  = P + 1;
   localparam int NL = 2;
   localparam int CNTW = segpoly_pkg::EDGE_CNT_W;
   localparam int IDXW = segpoly_pkg::HIT_IDX_W;

   typedef struct packed {
      logic signed [CW-1:0] sx0;
      logic signed [CW-1:0] sy0;
      logic signed [CW-1:0] sx1;
      logic signed [CW-1:0] sy1;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] fx;
      logic signed [CW-1:0] fy;
      logic                 a_valid;
      logic                 last;
   } segpoly_entry_type;

   function automatic logic signed [D-1:0] dif(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
      return D'(a) - D'(b);
   endfunction

   function automatic logic [CNTW-1:0] sat_inc(input logic [CNTW-1:0] c);
      return (c == segpoly_pkg::EDGE_CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [IDXW-1:0] clamp_idx(input logic [CNTW-1:0] c);
      return (c[CNTW-1:IDXW] != '0) ? segpoly_pkg::HIT_IDX_MAX : c[IDXW-1:0];
   endfunction

   segpoly_entry_type e;
   logic              adv;

   // stage 1: differences
   logic                s1_v_ff, s1_a_ff, s1_last_ff;
   logic signed [D-1:0] s1_rx_ff, s1_ry_ff;
   logic signed [D-1:0] s1_sx_ff [NL];
   logic signed [D-1:0] s1_sy_ff [NL];
   logic signed [D-1:0] s1_wx_ff [NL];
   logic signed [D-1:0] s1_wy_ff [NL];
   logic signed [D-1:0] s1_sx_in [NL];
   logic signed [D-1:0] s1_sy_in [NL];
   logic signed [D-1:0] s1_wx_in [NL];
   logic signed [D-1:0] s1_wy_in [NL];

   // stage 2: products
   logic                s2_v_ff, s2_a_ff, s2_last_ff;
   logic signed [P-1:0] s2_rsy_ff [NL];
   logic signed [P-1:0] s2_rys_ff [NL];
   logic signed [P-1:0] s2_wxr_ff [NL];
   logic signed [P-1:0] s2_wyr_ff [NL];
   logic signed [P-1:0] s2_wxs_ff [NL];
   logic signed [P-1:0] s2_wys_ff [NL];

   // stage 3: cross products
   logic                s3_v_ff, s3_a_ff, s3_last_ff;
   logic signed [S-1:0] s3_den_ff [NL];
   logic signed [S-1:0] s3_un_ff  [NL];
   logic signed [S-1:0] s3_tn_ff  [NL];

   // stage 4: edge hit flags
   logic                s4_v_ff, s4_a_ff, s4_last_ff;
   logic [NL-1:0]       s4_hit_ff, s4_hit_in;

   // accumulation
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                hit_ff, hit_in;
   logic [IDXW-1:0]     idx_ff, idx_in;
   logic [CNTW-1:0]     cnt_a, cnt_b;
   logic                hit_a, hit_b, hit_new, ovf;
   logic [IDXW-1:0]     idx_new;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [segpoly_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign e     = pop_data_i;
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign pop_o = adv && !qstat_i.empty;

   always_comb begin
      s1_sx_in[0] = dif(e.vx, e.px);
      s1_sy_in[0] = dif(e.vy, e.py);
      s1_wx_in[0] = dif(e.px, e.sx0);
      s1_wy_in[0] = dif(e.py, e.sy0);
      s1_sx_in[1] = dif(e.fx, e.vx);
      s1_sy_in[1] = dif(e.fy, e.vy);
      s1_wx_in[1] = dif(e.vx, e.sx0);
      s1_wy_in[1] = dif(e.vy, e.sy0);
   end

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         if (s3_den_ff[l] == '0) begin
            s4_hit_in[l] = (s3_un_ff[l] == '0);
         end else if (s3_den_ff[l][S-1]) begin
            s4_hit_in[l] = (s3_tn_ff[l] <= 0) && (s3_tn_ff[l] >= s3_den_ff[l]) &&
                           (s3_un_ff[l] <= 0) && (s3_un_ff[l] >= s3_den_ff[l]);
         end else begin
            s4_hit_in[l] = (s3_tn_ff[l] >= 0) && (s3_tn_ff[l] <= s3_den_ff[l]) &&
                           (s3_un_ff[l] >= 0) && (s3_un_ff[l] <= s3_den_ff[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= pop_o;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff    <= e.a_valid;
         s1_last_ff <= e.last;
         s1_rx_ff   <= dif(e.sx1, e.sx0);
         s1_ry_ff   <= dif(e.sy1, e.sy0);
         s2_a_ff    <= s1_a_ff;
         s2_last_ff <= s1_last_ff;
         s3_a_ff    <= s2_a_ff;
         s3_last_ff <= s2_last_ff;
         s4_a_ff    <= s3_a_ff;
         s4_last_ff <= s3_last_ff;
         s4_hit_ff  <= s4_hit_in;
         for (int l = 0; l < NL; l++) begin
            s1_sx_ff[l]  <= s1_sx_in[l];
            s1_sy_ff[l]  <= s1_sy_in[l];
            s1_wx_ff[l]  <= s1_wx_in[l];
            s1_wy_ff[l]  <= s1_wy_in[l];
            s2_rsy_ff[l] <= s1_rx_ff * s1_sy_ff[l];
            s2_rys_ff[l] <= s1_ry_ff * s1_sx_ff[l];
            s2_wxr_ff[l] <= s1_wx_ff[l] * s1_ry_ff;
            s2_wyr_ff[l] <= s1_wy_ff[l] * s1_rx_ff;
            s2_wxs_ff[l] <= s1_wx_ff[l] * s1_sy_ff[l];
            s2_wys_ff[l] <= s1_wy_ff[l] * s1_sx_ff[l];
            s3_den_ff[l] <= S'(s2_rsy_ff[l]) - S'(s2_rys_ff[l]);
            s3_un_ff[l]  <= S'(s2_wxr_ff[l]) - S'(s2_wyr_ff[l]);
            s3_tn_ff[l]  <= S'(s2_wxs_ff[l]) - S'(s2_wys_ff[l]);
         end
      end
   end

   always_comb begin
      cnt_a   = s4_a_ff ? sat_inc(cnt_ff) : cnt_ff;
      cnt_b   = s4_last_ff ? sat_inc(cnt_a) : cnt_a;
      hit_a   = s4_a_ff && s4_hit_ff[0];
      hit_b   = s4_last_ff && s4_hit_ff[1];
      hit_new = hit_ff || hit_a || hit_b;
      if (hit_ff) begin
         idx_new = idx_ff;
      end else if (hit_a) begin
         idx_new = clamp_idx(cnt_ff);
      end else if (hit_b) begin
         idx_new = clamp_idx(cnt_a);
      end else begin
         idx_new = idx_ff;
      end
      ovf = (32'(cnt_b) > 32'(segpoly_pkg::MAX_VERTICES)) ||
            (cnt_b == segpoly_pkg::EDGE_CNT_MAX);

      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         rsp_valid_in = s4_v_ff && s4_last_ff;
         if (s4_v_ff) begin
            if (s4_last_ff) begin
               cnt_in      = '0;
               hit_in      = 1'b0;
               idx_in      = '0;
               rsp_data_in = '0;
               rsp_data_in[0]        = hit_new;
               rsp_data_in[IDXW:1]   = hit_new ? idx_new : '0;
               rsp_data_in[IDXW+1]   = ovf;
            end else begin
               cnt_in = cnt_b;
               hit_in = hit_new;
               idx_in = idx_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
